### design/gnw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnw_pkg
// Types, constants and tables shared by the n-link weight block.
// ----------------------------------------------------------------------------
package gnw_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int EXP_BITS  = 12;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_GAMMA = 2'd2;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] chan2;
    logic [7:0] chan1;
    logic [7:0] chan0;
  } in_item_t;

  typedef struct packed {
    logic [15:0] left_weight;
    logic [15:0] upleft_weight;
    logic [15:0] up_weight;
    logic [15:0] upright_weight;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXP, ST_GAIN, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // capture input, read neighbours from the row store
    logic exp_start; // load exponent iterators from the products
    logic exp_step;  // one exponent bit per cycle
    logic gain;      // apply gains
  } cmd_t;

  typedef struct packed {
    logic exp_last;
  } stat_t;

  function automatic logic [15:0] exp_tab(input logic [3:0] i);
    case (i)
      4'd0:  exp_tab = 16'd22;
      4'd1:  exp_tab = 16'd1200;
      4'd2:  exp_tab = 16'd8869;
      4'd3:  exp_tab = 16'd24109;
      4'd4:  exp_tab = 16'd39750;
      4'd5:  exp_tab = 16'd51039;
      4'd6:  exp_tab = 16'd57835;
      4'd7:  exp_tab = 16'd61565;
      4'd8:  exp_tab = 16'd63520;
      4'd9:  exp_tab = 16'd64520;
      4'd10: exp_tab = 16'd65026;
      4'd11: exp_tab = 16'd65280;
      default: exp_tab = 16'd0;
    endcase
  endfunction

endpackage

### design/grabcut_nlink_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grabcut_nlink_weights
// Top level: APB registers, controller and datapath.
// ----------------------------------------------------------------------------
// Each pixel passes through these steps in order: capture it and read the row
// store at its column and the next, form the four beta*distance products, the
// exponent, set by one table bit per cycle shared by the four lanes, the gains,
// and hand-over of the result, which is held while the output stalls. The next
// pixel is taken in the cycle after the result has gone. No clearing pass.
module grabcut_nlink_weights
  import gnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] image_width;
  logic [31:0] contrast_scale;
  logic [15:0] smooth_gain;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 12'd640;
      contrast_scale <= 32'd16777;
      smooth_gain    <= 16'd3200;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH: image_width    <= pwdata[11:0];
        REG_BETA:  contrast_scale <= pwdata;
        REG_GAMMA: smooth_gain    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_WIDTH: prdata = {20'd0, image_width};
      REG_BETA:  prdata = contrast_scale;
      REG_GAMMA: prdata = {16'd0, smooth_gain};
      default:   prdata = '0;
    endcase
  end

  gnw_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  gnw_datapath u_dp (
    .clk, .rst, .cmd, .stat, .in_item(in_data), .image_width, .contrast_scale,
    .smooth_gain, .out_item(out_data)
  );

`ifndef SYNTHESIS
  a_in_out_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_take_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("sequencer skipped work");
`endif

endmodule

### design/gnw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnw_ctrl
// Sequencer for one pixel: capture and store read, products, exponent steps,
// gain, output.
// ----------------------------------------------------------------------------
module gnw_ctrl
  import gnw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.exp_start = 1'b1;
        state_next    = ST_EXP;
      end
      ST_EXP: begin
        cmd.exp_step = 1'b1;
        if (stat.exp_last) state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### design/gnw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnw_datapath
// Row store, neighbour registers, distance, exponent iteration and gains.
// ----------------------------------------------------------------------------
module gnw_datapath
  import gnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  in_item_t    in_item,
  input  logic [11:0] image_width,
  input  logic [31:0] contrast_scale,
  input  logic [15:0] smooth_gain,
  output out_item_t   out_item
);

  logic [23:0] row_store [MAX_WIDTH];
  logic [23:0] prev_pixel, old_upleft, pix, above, upright;
  logic [CNT_W-1:0] column;
  logic        first_row;
  logic [CNT_W-1:0] w_eff, col_in, col_inc;
  logic        first_in;
  logic        lv, ulv, uv, urv;
  logic [23:0] nb_left;
  logic [23:0] nb_prev_ul;
  logic [17:0] dsq [4];
  logic [49:0] prod [4];
  logic [11:0] pbits [4];
  logic        zero [4];
  logic [16:0] e [4];
  logic [3:0]  step;
  logic [15:0] gd;
  logic [31:0] gd_full;
  logic [15:0] wt [4];

  // effective width, clamped to 1..MAX_WIDTH
  always_comb begin
    if (image_width == 12'd0) w_eff = CNT_W'(1);
    else if ({1'b0, image_width} > 13'(MAX_WIDTH)) w_eff = CNT_W'(MAX_WIDTH);
    else w_eff = CNT_W'(image_width);
  end

  // column before this pixel
  always_comb begin
    col_in   = in_item.frame_start ? '0 : column;
    first_in = in_item.frame_start ? 1'b1 : first_row;
    if (col_in >= w_eff) begin
      col_in   = '0;
      first_in = 1'b0;
    end
    col_inc = col_in + CNT_W'(1);
  end

  // capture pixel, read above, advance position
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pixel <= '0;
      old_upleft <= '0;
      column     <= '0;
      first_row  <= 1'b1;
    end else if (cmd.take) begin
      prev_pixel <= {in_item.chan2, in_item.chan1, in_item.chan0};
      nb_prev_ul <= old_upleft;
      old_upleft <= row_store[col_in[COL_W-1:0]];
      if (col_inc >= w_eff) begin
        column    <= '0;
        first_row <= 1'b0;
      end else begin
        column    <= col_inc;
        first_row <= first_in;
      end
    end
  end

  // hold the pixel and its flags, write the store, read the upper-right entry
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix     <= {in_item.chan2, in_item.chan1, in_item.chan0};
      nb_left <= prev_pixel;
      lv      <= col_in != '0;
      ulv     <= (col_in != '0) && !first_in;
      uv      <= !first_in;
      urv     <= !first_in && (col_inc < w_eff);
      row_store[col_in[COL_W-1:0]] <= {in_item.chan2, in_item.chan1, in_item.chan0};
      upright <= row_store[col_inc[COL_W-1:0]];
    end
  end

  assign above = old_upleft;

  // squared distances and products, combinational
  always_comb begin
    logic signed [8:0] d;
    for (int k = 0; k < 4; k++) begin
      logic [23:0] b;
      b = (k == 0) ? nb_left : (k == 1) ? nb_prev_ul : (k == 2) ? above : upright;
      dsq[k] = '0;
      for (int c = 0; c < 3; c++) begin
        d = $signed({1'b0, pix[8*c +: 8]}) - $signed({1'b0, b[8*c +: 8]});
        dsq[k] = dsq[k] + 18'(d * d);
      end
      prod[k] = contrast_scale * dsq[k];
    end
  end

  // exponent: one table bit per cycle over all four lanes
  always_ff @(posedge clk) begin
    if (cmd.exp_start) begin
      step <= '0;
      for (int k = 0; k < 4; k++) begin
        zero[k]  <= prod[k][49:28] != '0;
        pbits[k] <= prod[k][27:16];
        e[k]     <= 17'd65536;
      end
    end else if (cmd.exp_step) begin
      step <= step + 4'd1;
      for (int k = 0; k < 4; k++) begin
        if (pbits[k][4'd11 - step])
          e[k] <= 17'((34'(e[k]) * exp_tab(step) + 34'd32768) >> 16);
      end
    end
  end

  assign stat.exp_last = step == 4'(EXP_BITS - 1);

  assign gd_full = smooth_gain * 32'd46341 + 32'd32768;
  assign gd      = gd_full[31:16];

  // gains and border masks
  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      for (int k = 0; k < 4; k++) begin
        logic [15:0] g;
        logic [33:0] t;
        logic        v;
        g = (k == 0 || k == 2) ? smooth_gain : gd;
        v = (k == 0) ? lv : (k == 1) ? ulv : (k == 2) ? uv : urv;
        t = g * (zero[k] ? 17'd0 : e[k]) + 34'd32768;
        wt[k] <= v ? t[31:16] : 16'd0;
      end
    end
  end

  assign out_item.left_weight    = wt[0];
  assign out_item.upleft_weight  = wt[1];
  assign out_item.up_weight      = wt[2];
  assign out_item.upright_weight = wt[3];

endmodule
